FILE: rtl/core/dfsmg_pkg.sv
// ----------------------------------------------------------------------------
// dfsmg_pkg
// shared types, constants and helper functions of the maze generator
// ----------------------------------------------------------------------------
package dfsmg_pkg;

   localparam int SEED_W     = 32;
   localparam int ROW_W      = 63;
   localparam int ROWIDX_W   = 6;
   localparam int CELL_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam int DEF_MAX_WIDTH_CELLS  = 31;
   localparam int DEF_MAX_HEIGHT_CELLS = 31;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_CELLS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_CELLS = 1'd1;

   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 5'd16;

   // twister
   localparam int TW_N  = 624;
   localparam int TW_M  = 397;
   localparam int TW_AW = 10;
   localparam logic [31:0] TW_SEED_MULT = 32'd1812433253;
   localparam logic [31:0] TW_MATRIX    = 32'h9908b0df;

   localparam logic [ROW_W-1:0] ROW_ALL_WALL = {ROW_W{1'b1}};

   // neighbor direction codes, in checking order
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   function automatic logic [31:0] tw_temper(input logic [31:0] y_in);
      logic [31:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // (2^32 - n) mod n for n of one to four candidates
   function automatic logic [31:0] lemire_thresh(input logic [2:0] n);
      logic [31:0] t;
      unique case (n)
         3'd3:    t = 32'd1;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/core/dfsmg_req_if.sv
// ----------------------------------------------------------------------------
// dfsmg_req_if
// seed request channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dfsmg_req_if;
   logic                        valid;
   logic                        ready;
   logic [dfsmg_pkg::SEED_W-1:0] seed;

   modport source (output valid, output seed, input ready);
   modport sink   (input valid, input seed, output ready);
endinterface

FILE: rtl/core/dfsmg_rsp_if.sv
// ----------------------------------------------------------------------------
// dfsmg_rsp_if
// maze row response channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dfsmg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dfsmg_pkg::ROWIDX_W-1:0] row_index;
   logic [dfsmg_pkg::ROW_W-1:0]    wall_bits;
   logic                          last_row;

   modport source (output valid, output row_index, output wall_bits, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input wall_bits, input last_row,
                   output ready);
endinterface

FILE: rtl/core/dfs_maze_generator.sv
// ----------------------------------------------------------------------------
// dfs_maze_generator
// recursive backtracker maze generator driven by an mt19937 twister
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake         payload
//  -------   ---   ---------------   ------------------------------------
//  req_ch    in    valid/ready       seed[31:0]
//  rsp_ch    out   valid/ready       row_index[5:0] wall_bits[62:0] last_row
//  csr_*     in    write enable      csr_index[0], csr_wdata[4:0]
//
//  one seed at a time; req is ready only while no maze is in progress
//  seeding: one twister word written per cycle
//  walk: the grid row memory has a single read port, so the three rows
//    of each step are read one after another
//  twist: all 624 words regenerated once every 624 draws
//  emit: one grid row at a time, held while rsp is stalled
//  reset: synchronous, no clearing pass needed
//
module dfs_maze_generator #(
   parameter int MAX_WIDTH_CELLS  = dfsmg_pkg::DEF_MAX_WIDTH_CELLS,
   parameter int MAX_HEIGHT_CELLS = dfsmg_pkg::DEF_MAX_HEIGHT_CELLS
) (
   input  logic                              clock,
   input  logic                              reset,
   dfsmg_req_if.sink                         req_ch,
   dfsmg_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [dfsmg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dfsmg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int GRID_ROWS = 2 * MAX_HEIGHT_CELLS + 1;
   localparam int GRID_AW   = $clog2(GRID_ROWS);
   localparam int STK_DEPTH = MAX_WIDTH_CELLS * MAX_HEIGHT_CELLS;
   localparam int STK_IW    = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
   localparam int STK_CW    = $clog2(STK_DEPTH + 1);
   localparam int CW        = dfsmg_pkg::CELL_W;
   localparam int RW        = dfsmg_pkg::ROW_W;
   localparam int RIW       = dfsmg_pkg::ROWIDX_W;
   localparam int TAW       = dfsmg_pkg::TW_AW;

   typedef enum logic [4:0] {
      S_IDLE, S_SEED, S_INIT,
      S_RD_UP, S_RD_CUR, S_RD_DN, S_EVAL, S_POP,
      S_DRAW_RD, S_DRAW_GOT,
      S_TW_START, S_TW_LOAD, S_TW_B, S_TW_C,
      S_OPEN, S_MID, S_PUSH,
      S_EMIT_RD, S_EMIT_LD
   } state_type;

   state_type state_ff;

   // configuration
   logic [CW-1:0] width_cfg_ff, height_cfg_ff;
   logic [CW-1:0] w_ff, h_ff;
   logic [CW-1:0] w_clamp, h_clamp;

   // walk state
   logic [CW-1:0]     cell_r_ff, cell_c_ff;
   logic [CW-1:0]     new_r_ff, new_c_ff;
   logic [STK_CW-1:0] depth_ff;
   logic [RW-1:0]     up_row_ff, cur_row_ff, dn_row_ff;
   logic [3:0]        cand_ff;
   logic [2:0]        ncand_ff;
   logic [1:0]        dir_ff;
   logic [RIW-1:0]    mid_addr_ff;
   logic [RIW-1:0]    emit_r_ff;

   // twister state
   logic [TAW-1:0] tw_idx_ff;
   logic [TAW-1:0] tw_i_ff;
   logic [31:0]    tw_prev_ff;
   logic [31:0]    tw_cur_ff;
   logic [31:0]    tw_nxt_ff;

   // output register
   logic           rsp_valid_ff;
   logic [RIW-1:0] rsp_row_ff;
   logic [RW-1:0]  rsp_bits_ff;
   logic           rsp_last_ff;

   // memories
   logic [RW-1:0]        grid_mem [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_vld_ff;
   logic [RW-1:0]        grid_q_ff;
   logic                 grid_qv_ff;
   logic [31:0]          tw_mem [dfsmg_pkg::TW_N];
   logic [31:0]          tw_q_ff;
   logic [2*CW-1:0]      stk_mem [STK_DEPTH];
   logic [2*CW-1:0]      stk_q_ff;

   logic                 grid_we;
   logic [RIW-1:0]       grid_waddr, grid_raddr;
   logic [RW-1:0]        grid_wdata;
   logic                 tw_we;
   logic [TAW-1:0]       tw_waddr, tw_raddr;
   logic [31:0]          tw_wdata;
   logic                 stk_we;
   logic [STK_IW-1:0]    stk_waddr, stk_raddr;
   logic [2*CW-1:0]      stk_wdata;

   // derived walk values
   logic [RIW-1:0] cr, cc;
   logic [RIW-1:0] up_addr, dn_addr;
   logic [RW-1:0]  grid_row;
   logic           up_ok, dn_ok, lt_ok, rt_ok;
   logic [3:0]     cand;
   logic [2:0]     ncand;
   logic [STK_CW-1:0] depth_dec;

   // draw values
   logic [31:0] draw_x;
   logic [33:0] draw_p;
   logic        draw_retry;
   logic [2:0]  draw_k;
   logic [1:0]  draw_dir;
   logic [2:0]  sel_cnt;

   // twist values
   logic [TAW:0]   tw_sum_m, tw_sum_2;
   logic [TAW-1:0] tw_addr_m, tw_addr_2;
   logic [31:0]    tw_v, tw_nv;
   logic [31:0]    seed_nv;
   logic [63:0]    col_mask;

   logic req_fire, rsp_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_valid_ff && rsp_ch.ready;

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_row_ff;
   assign rsp_ch.wall_bits = rsp_bits_ff;
   assign rsp_ch.last_row  = rsp_last_ff;

   // size registers: zero means one cell, saturate at the maximum
   always_comb begin
      if (width_cfg_ff == '0) begin
         w_clamp = CW'(1);
      end else if (width_cfg_ff > CW'(MAX_WIDTH_CELLS)) begin
         w_clamp = CW'(MAX_WIDTH_CELLS);
      end else begin
         w_clamp = width_cfg_ff;
      end
      if (height_cfg_ff == '0) begin
         h_clamp = CW'(1);
      end else if (height_cfg_ff > CW'(MAX_HEIGHT_CELLS)) begin
         h_clamp = CW'(MAX_HEIGHT_CELLS);
      end else begin
         h_clamp = height_cfg_ff;
      end
   end

   // grid coordinates of the cell on top of the stack
   assign cr      = {cell_r_ff, 1'b1};
   assign cc      = {cell_c_ff, 1'b1};
   assign up_addr = (cell_r_ff != '0) ? RIW'(cr - RIW'(2)) : cr;
   assign dn_addr = ((RIW'(cell_r_ff) + RIW'(1)) < RIW'(h_ff)) ? RIW'(cr + RIW'(2)) : cr;

   // rows never written since the seed read as solid wall
   assign grid_row = grid_qv_ff ? grid_q_ff : dfsmg_pkg::ROW_ALL_WALL;

   // neighbor checks, down row arrives from memory in the eval cycle
   always_comb begin
      up_ok = (cell_r_ff != '0) && up_row_ff[cc];
      dn_ok = ((RIW'(cell_r_ff) + RIW'(1)) < RIW'(h_ff)) && grid_row[cc];
      lt_ok = (cell_c_ff != '0) && cur_row_ff[RIW'(cc - RIW'(2))];
      rt_ok = ((RIW'(cell_c_ff) + RIW'(1)) < RIW'(w_ff)) && cur_row_ff[RIW'(cc + RIW'(2))];
      cand  = {rt_ok, lt_ok, dn_ok, up_ok};
      ncand = 3'($countones(cand));
   end

   assign depth_dec = STK_CW'(depth_ff - STK_CW'(1));

   // bounded draw: x * n, low word against the threshold
   always_comb begin
      draw_x     = dfsmg_pkg::tw_temper(tw_q_ff);
      draw_p     = {2'b00, draw_x} * {31'd0, ncand_ff};
      draw_retry = draw_p[31:0] < dfsmg_pkg::lemire_thresh(ncand_ff);
      draw_k     = {1'b0, draw_p[33:32]};
      if (draw_k >= ncand_ff) begin
         draw_k = 3'(ncand_ff - 3'd1);
      end
      // k-th candidate in checking order
      draw_dir = dfsmg_pkg::DIR_UP;
      sel_cnt  = 3'd0;
      for (int d = 0; d < 4; d++) begin
         if (cand_ff[d]) begin
            if (sel_cnt == draw_k) begin
               draw_dir = 2'(d);
            end
            sel_cnt = 3'(sel_cnt + 3'd1);
         end
      end
   end

   // twister arithmetic
   always_comb begin
      tw_sum_m  = (TAW+1)'(tw_i_ff) + (TAW+1)'(dfsmg_pkg::TW_M);
      tw_addr_m = (tw_sum_m >= (TAW+1)'(dfsmg_pkg::TW_N)) ?
                  TAW'(tw_sum_m - (TAW+1)'(dfsmg_pkg::TW_N)) : TAW'(tw_sum_m);
      tw_sum_2  = (TAW+1)'(tw_i_ff) + (TAW+1)'(2);
      tw_addr_2 = (tw_sum_2 >= (TAW+1)'(dfsmg_pkg::TW_N)) ?
                  TAW'(tw_sum_2 - (TAW+1)'(dfsmg_pkg::TW_N)) : TAW'(tw_sum_2);
      tw_v      = {tw_cur_ff[31], tw_nxt_ff[30:0]};
      tw_nv     = tw_q_ff ^ (tw_v >> 1);
      if (tw_v[0]) begin
         tw_nv = tw_nv ^ dfsmg_pkg::TW_MATRIX;
      end
      seed_nv   = 32'(dfsmg_pkg::TW_SEED_MULT * (tw_prev_ff ^ (tw_prev_ff >> 30)))
                  + 32'(tw_i_ff);
   end

   assign col_mask = (64'd1 << {w_ff, 1'b1}) - 64'd1;

   // memory port control
   always_comb begin
      grid_we    = 1'b0;
      grid_waddr = cr;
      grid_wdata = cur_row_ff;
      grid_raddr = cr;
      tw_we      = 1'b0;
      tw_waddr   = tw_i_ff;
      tw_wdata   = seed_nv;
      tw_raddr   = tw_idx_ff;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[STK_IW-1:0];
      stk_wdata  = {new_r_ff, new_c_ff};
      stk_raddr  = STK_IW'(depth_dec - STK_CW'(1));
      unique case (state_ff)
         S_IDLE: begin
            tw_we    = req_fire;
            tw_waddr = '0;
            tw_wdata = req_ch.seed;
         end
         S_SEED: begin
            tw_we = 1'b1;
         end
         S_INIT: begin
            grid_we    = 1'b1;
            grid_waddr = RIW'(1);
            grid_wdata = dfsmg_pkg::ROW_ALL_WALL & ~(RW'(1) << 1);
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_wdata  = '0;
         end
         S_RD_UP:  grid_raddr = up_addr;
         S_RD_CUR: grid_raddr = cr;
         S_RD_DN:  grid_raddr = dn_addr;
         S_TW_START: tw_raddr = '0;
         S_TW_LOAD:  tw_raddr = TAW'(1);
         S_TW_B:     tw_raddr = tw_addr_m;
         S_TW_C: begin
            tw_we    = 1'b1;
            tw_wdata = tw_nv;
            tw_raddr = tw_addr_2;
         end
         S_OPEN: begin
            grid_we = 1'b1;
            unique case (dir_ff)
               dfsmg_pkg::DIR_UP: begin
                  grid_waddr = up_addr;
                  grid_wdata = up_row_ff & ~(RW'(1) << cc);
                  grid_raddr = RIW'(cr - RIW'(1));
               end
               dfsmg_pkg::DIR_DOWN: begin
                  grid_waddr = dn_addr;
                  grid_wdata = dn_row_ff & ~(RW'(1) << cc);
                  grid_raddr = RIW'(cr + RIW'(1));
               end
               dfsmg_pkg::DIR_LEFT: begin
                  grid_wdata = cur_row_ff & ~(RW'(3) << RIW'(cc - RIW'(2)));
               end
               default: begin
                  grid_wdata = cur_row_ff & ~(RW'(3) << RIW'(cc + RIW'(1)));
               end
            endcase
         end
         S_MID: begin
            grid_we    = 1'b1;
            grid_waddr = mid_addr_ff;
            grid_wdata = grid_row & ~(RW'(1) << cc);
         end
         S_PUSH: begin
            stk_we = (depth_ff < STK_CW'(STK_DEPTH));
         end
         S_EMIT_RD: grid_raddr = emit_r_ff;
         default: begin
         end
      endcase
   end

   // grid row memory
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr[GRID_AW-1:0]] <= grid_wdata;
      end
      grid_q_ff  <= grid_mem[grid_raddr[GRID_AW-1:0]];
      grid_qv_ff <= row_vld_ff[grid_raddr[GRID_AW-1:0]];
   end

   // twister word memory
   always_ff @(posedge clock) begin
      if (tw_we) begin
         tw_mem[tw_waddr] <= tw_wdata;
      end
      tw_q_ff <= tw_mem[tw_raddr];
   end

   // cell stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_q_ff <= stk_mem[stk_raddr];
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         width_cfg_ff  <= dfsmg_pkg::SIZE_RESET;
         height_cfg_ff <= dfsmg_pkg::SIZE_RESET;
         row_vld_ff    <= '0;
         depth_ff      <= '0;
         tw_idx_ff     <= TAW'(dfsmg_pkg::TW_N);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               dfsmg_pkg::REG_WIDTH_CELLS:  width_cfg_ff  <= csr_wdata;
               dfsmg_pkg::REG_HEIGHT_CELLS: height_cfg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         if (grid_we) begin
            row_vld_ff[grid_waddr[GRID_AW-1:0]] <= 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  w_ff       <= w_clamp;
                  h_ff       <= h_clamp;
                  tw_prev_ff <= req_ch.seed;
                  tw_i_ff    <= TAW'(1);
                  row_vld_ff <= '0;
                  state_ff   <= S_SEED;
               end
            end
            S_SEED: begin
               tw_prev_ff <= seed_nv;
               if (tw_i_ff == TAW'(dfsmg_pkg::TW_N - 1)) begin
                  tw_idx_ff <= TAW'(dfsmg_pkg::TW_N);
                  state_ff  <= S_INIT;
               end else begin
                  tw_i_ff <= TAW'(tw_i_ff + TAW'(1));
               end
            end
            S_INIT: begin
               cell_r_ff <= '0;
               cell_c_ff <= '0;
               depth_ff  <= STK_CW'(1);
               state_ff  <= S_RD_UP;
            end
            S_RD_UP:  state_ff <= S_RD_CUR;
            S_RD_CUR: begin
               up_row_ff <= grid_row;
               state_ff  <= S_RD_DN;
            end
            S_RD_DN: begin
               cur_row_ff <= grid_row;
               state_ff   <= S_EVAL;
            end
            S_EVAL: begin
               dn_row_ff <= grid_row;
               cand_ff   <= cand;
               ncand_ff  <= ncand;
               if (ncand != 3'd0) begin
                  state_ff <= S_DRAW_RD;
               end else begin
                  // dead end: backtrack
                  depth_ff <= depth_dec;
                  if (depth_dec == '0) begin
                     emit_r_ff <= '0;
                     state_ff  <= S_EMIT_RD;
                  end else begin
                     state_ff <= S_POP;
                  end
               end
            end
            S_POP: begin
               cell_r_ff <= stk_q_ff[2*CW-1:CW];
               cell_c_ff <= stk_q_ff[CW-1:0];
               state_ff  <= S_RD_UP;
            end
            S_DRAW_RD: begin
               if (tw_idx_ff >= TAW'(dfsmg_pkg::TW_N)) begin
                  tw_i_ff  <= '0;
                  state_ff <= S_TW_START;
               end else begin
                  tw_idx_ff <= TAW'(tw_idx_ff + TAW'(1));
                  state_ff  <= S_DRAW_GOT;
               end
            end
            S_DRAW_GOT: begin
               if (draw_retry) begin
                  state_ff <= S_DRAW_RD;
               end else begin
                  dir_ff <= draw_dir;
                  unique case (draw_dir)
                     dfsmg_pkg::DIR_UP: begin
                        new_r_ff <= CW'(cell_r_ff - CW'(1));
                        new_c_ff <= cell_c_ff;
                     end
                     dfsmg_pkg::DIR_DOWN: begin
                        new_r_ff <= CW'(cell_r_ff + CW'(1));
                        new_c_ff <= cell_c_ff;
                     end
                     dfsmg_pkg::DIR_LEFT: begin
                        new_r_ff <= cell_r_ff;
                        new_c_ff <= CW'(cell_c_ff - CW'(1));
                     end
                     default: begin
                        new_r_ff <= cell_r_ff;
                        new_c_ff <= CW'(cell_c_ff + CW'(1));
                     end
                  endcase
                  state_ff <= S_OPEN;
               end
            end
            S_TW_START: state_ff <= S_TW_LOAD;
            S_TW_LOAD: begin
               tw_cur_ff <= tw_q_ff;
               state_ff  <= S_TW_B;
            end
            S_TW_B: begin
               tw_nxt_ff <= tw_q_ff;
               state_ff  <= S_TW_C;
            end
            S_TW_C: begin
               tw_cur_ff <= tw_nxt_ff;
               if (tw_i_ff == TAW'(dfsmg_pkg::TW_N - 1)) begin
                  tw_idx_ff <= '0;
                  state_ff  <= S_DRAW_RD;
               end else begin
                  tw_i_ff  <= TAW'(tw_i_ff + TAW'(1));
                  state_ff <= S_TW_B;
               end
            end
            S_OPEN: begin
               if (dir_ff == dfsmg_pkg::DIR_UP) begin
                  mid_addr_ff <= RIW'(cr - RIW'(1));
                  state_ff    <= S_MID;
               end else if (dir_ff == dfsmg_pkg::DIR_DOWN) begin
                  mid_addr_ff <= RIW'(cr + RIW'(1));
                  state_ff    <= S_MID;
               end else begin
                  state_ff <= S_PUSH;
               end
            end
            S_MID: state_ff <= S_PUSH;
            S_PUSH: begin
               if (depth_ff < STK_CW'(STK_DEPTH)) begin
                  depth_ff <= STK_CW'(depth_ff + STK_CW'(1));
               end
               cell_r_ff <= new_r_ff;
               cell_c_ff <= new_c_ff;
               state_ff  <= S_RD_UP;
            end
            S_EMIT_RD: begin
               // wait for the output register to drain
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  state_ff <= S_EMIT_LD;
               end
            end
            S_EMIT_LD: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= emit_r_ff;
               rsp_bits_ff  <= grid_row & col_mask[RW-1:0];
               rsp_last_ff  <= (emit_r_ff == {h_ff, 1'b0});
               if (emit_r_ff == {h_ff, 1'b0}) begin
                  state_ff <= S_IDLE;
               end else begin
                  emit_r_ff <= RIW'(emit_r_ff + RIW'(1));
                  state_ff  <= S_EMIT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: sim/dfs_maze_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfs_maze_generator_tb
// self-checking bench for the maze generator: seeds go in over the request
// channel, every emitted grid row is checked against a software twister and
// backtracker walk kept in the bench, across several maze sizes
// ----------------------------------------------------------------------------
module dfs_maze_generator_tb;

   localparam int CYCLE_LIMIT = 8000000;
   localparam int MAXW = dfsmg_pkg::DEF_MAX_WIDTH_CELLS;
   localparam int MAXH = dfsmg_pkg::DEF_MAX_HEIGHT_CELLS;
   localparam int ROWIDX_W   = dfsmg_pkg::ROWIDX_W;
   localparam int ROW_W      = dfsmg_pkg::ROW_W;
   localparam int CSR_IDX_W  = dfsmg_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = dfsmg_pkg::CSR_DATA_W;
   localparam int TW_N       = dfsmg_pkg::TW_N;
   localparam int TW_M       = dfsmg_pkg::TW_M;

   typedef struct packed {
      logic [ROWIDX_W-1:0] row_index;
      logic [ROW_W-1:0]    wall_bits;
      logic                last_row;
   } maze_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dfsmg_req_if req_ch ();
   dfsmg_rsp_if rsp_ch ();

   dfs_maze_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copies of the size registers
   logic [CSR_DATA_W-1:0] width_reg  = dfsmg_pkg::SIZE_RESET;
   logic [CSR_DATA_W-1:0] height_reg = dfsmg_pkg::SIZE_RESET;

   logic [31:0]  seed_queue[$];     // seeds still to be sent
   maze_row_type row_queue[$];      // rows the block should still emit
   bit           idling_on = 1'b1;
   int           error_count = 0;
   int           cycle_count = 0;
   int           maze_count = 0;
   int           row_count = 0;
   int           send_gap = 0;
   int           recv_stall = 0;

   // twister state
   logic [31:0] tw_words[TW_N];
   int          tw_pos;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // append one seed to the pending queue
   task automatic queue_seed(input logic [31:0] s);
      seed_queue = {seed_queue, s};
   endtask

   function automatic logic [31:0] twister_draw();
      logic [31:0] v;
      logic [31:0] y;
      if (tw_pos >= TW_N) begin
         for (int i = 0; i < TW_N; i++) begin
            v = (tw_words[i] & 32'h80000000) | (tw_words[(i + 1) % TW_N] & 32'h7fffffff);
            tw_words[i] = tw_words[(i + TW_M) % TW_N] ^ (v >> 1);
            if (v[0]) tw_words[i] = tw_words[i] ^ 32'h9908b0df;
         end
         tw_pos = 0;
      end
      y = tw_words[tw_pos];
      tw_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // lemire bounded index below n
   function automatic int pick_below(input int n);
      logic [63:0] p;
      logic [31:0] t;
      p = 64'(twister_draw()) * 64'(n);
      if (p[31:0] < 32'(n)) begin
         t = (32'd0 - 32'(n)) % 32'(n);
         while (p[31:0] < t) p = 64'(twister_draw()) * 64'(n);
      end
      return int'(p[63:32]);
   endfunction

   // walks the maze for one seed and queues its rows
   function automatic void predict_maze(input logic [31:0] seed);
      logic [ROW_W-1:0] grid[63];
      int stack_cells[MAXW*MAXH];
      int depth, w, h, rows, cols, cr, cc, nr, nc, n, k;
      int cand_r[4];
      int cand_c[4];
      int dr[4] = '{-2, 2, 0, 0};
      int dc[4] = '{0, 0, -2, 2};
      maze_row_type item;
      w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : int'(width_reg));
      h = (height_reg == 0) ? 1 : ((height_reg > MAXH) ? MAXH : int'(height_reg));
      rows = 2 * h + 1;
      cols = 2 * w + 1;
      tw_words[0] = seed;
      for (int i = 1; i < TW_N; i++)
         tw_words[i] = 32'd1812433253 * (tw_words[i-1] ^ (tw_words[i-1] >> 30)) + 32'(i);
      tw_pos = TW_N;
      for (int r = 0; r < 63; r++) grid[r] = dfsmg_pkg::ROW_ALL_WALL;
      grid[1][1] = 1'b0;
      stack_cells[0] = 0;
      depth = 1;
      while (depth > 0) begin
         cr = 2 * (stack_cells[depth-1] / MAXW) + 1;
         cc = 2 * (stack_cells[depth-1] % MAXW) + 1;
         n = 0;
         // candidates in order up, down, left, right
         for (int d = 0; d < 4; d++) begin
            nr = cr + dr[d];
            nc = cc + dc[d];
            if (nr > 0 && nr < rows - 1 && nc > 0 && nc < cols - 1 && grid[nr][nc]) begin
               cand_r[n] = nr;
               cand_c[n] = nc;
               n++;
            end
         end
         if (n > 0) begin
            k = pick_below(n);
            if (k >= n) k = n - 1;
            nr = cand_r[k];
            nc = cand_c[k];
            grid[(cr + nr) / 2][(cc + nc) / 2] = 1'b0;
            grid[nr][nc] = 1'b0;
            if (depth < MAXW * MAXH) begin
               stack_cells[depth] = ((nr - 1) / 2) * MAXW + (nc - 1) / 2;
               depth++;
            end
         end else begin
            depth--;
         end
      end
      for (int r = 0; r < rows; r++) begin
         item.row_index = ROWIDX_W'(r);
         item.wall_bits = grid[r] & ((63'd1 << cols) - 63'd1);
         item.last_row  = (r == rows - 1);
         row_queue = {row_queue, item};
      end
      maze_count++;
   endfunction

   // seed driver: one transaction per accepted seed, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_maze(req_ch.seed);
            void'(seed_queue.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (seed_queue.size() > 0) begin
               if (idling_on && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 6) - 1;
                  req_ch.valid <= 1'b0;
               end else begin
                  req_ch.valid <= 1'b1;
                  req_ch.seed  <= seed_queue[0];
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // row monitor: compare each row transaction with the oldest expected row
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            row_count++;
            if (row_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected row %0d", rsp_ch.row_index));
            end else begin
               if (rsp_ch.row_index !== row_queue[0].row_index)
                  report_mismatch($sformatf("row_index got %0d want %0d",
                                            rsp_ch.row_index, row_queue[0].row_index));
               if (rsp_ch.wall_bits !== row_queue[0].wall_bits)
                  report_mismatch($sformatf("row %0d wall_bits got %h want %h",
                                            row_queue[0].row_index, rsp_ch.wall_bits,
                                            row_queue[0].wall_bits));
               if (rsp_ch.last_row !== row_queue[0].last_row)
                  report_mismatch($sformatf("row %0d last_row got %b want %b",
                                            row_queue[0].row_index, rsp_ch.last_row,
                                            row_queue[0].last_row));
               void'(row_queue.pop_front());
            end
         end
         // receiver back-pressure in bursts
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(1, 6) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // write both size registers while the block is idle
   task automatic set_size(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= dfsmg_pkg::REG_WIDTH_CELLS;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= dfsmg_pkg::REG_HEIGHT_CELLS;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg  = w;
      height_reg = h;
   endtask

   // wait for every seed to go out and every row to come back, then settle
   task automatic drain();
      while (seed_queue.size() > 0 || row_queue.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [CSR_DATA_W-1:0] w, h;
      w = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(20, 31))
                                      : CSR_DATA_W'($urandom_range(0, 7));
      h = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(20, 31))
                                      : CSR_DATA_W'($urandom_range(0, 7));
      set_size(w, h);
      for (int i = 0; i < count; i++) queue_seed($urandom());
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = dfsmg_pkg::REG_WIDTH_CELLS;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.seed  = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default 16 by 16 size straight out of reset, extreme seeds
      queue_seed(32'h0000_0000);
      queue_seed(32'hffff_ffff);
      drain();
      // zero sizes read as a single cell
      set_size(5'd0, 5'd0);
      queue_seed(32'd5);
      drain();
      set_size(5'd1, 5'd1);
      queue_seed(32'h5555_5555);
      drain();
      // largest maze, long enough to force twists
      set_size(5'd31, 5'd31);
      queue_seed(32'h8000_0000);
      queue_seed(32'h0000_0001);
      drain();
      // thin mazes: one row or one column of cells
      set_size(5'd31, 5'd1);
      queue_seed(32'haaaa_aaaa);
      queue_seed(32'd5489);
      drain();
      set_size(5'd1, 5'd31);
      queue_seed(32'h1234_5678);
      queue_seed(32'hdead_beef);
      drain();
      set_size(5'd2, 5'd3);
      for (int i = 0; i < 6; i++) queue_seed($urandom());
      drain();

      // random sizes and seeds, mostly small mazes
      for (int p = 0; p < 9; p++) random_phase(9);
      // last stretch runs with no idling on either side
      idling_on = 1'b0;
      random_phase(10);

      $display("checked %0d mazes, %0d rows, over %0d cycles", maze_count, row_count,
               cycle_count);
      $display("sizes from a single cell up to 31 by 31, with random idling and stalls");
      if (error_count == 0 && row_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d rows missing", error_count, row_queue.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/dfsmg_pkg.sv
rtl/core/dfsmg_req_if.sv
rtl/core/dfsmg_rsp_if.sv
rtl/core/dfs_maze_generator.sv
sim/dfs_maze_generator_tb.sv
